@@ rtl/core/crt_sieve_timestamp_top_assert.svh @@
// Assertion macros for the timestamp sieve block.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef CRT_SIEVE_TIMESTAMP_TOP_ASSERT_SVH
`define CRT_SIEVE_TIMESTAMP_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define CRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crts port check failed");

// Next-cycle implication, ignored while reset is held
`define CRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crts port check failed");

// Next-cycle implication, checked through reset as well
`define CRTS_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crts port check failed");

`endif

@@ rtl/core/crts_pkg.sv @@
// Shared types and constants of the timestamp sieve block.
// No dependencies; imported by every module of the block.
package crts_pkg;

  localparam int TS_W            = 63;
  localparam int PER_W           = 16;
  localparam int MAX_ENTRIES_DEF = 256;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Dividend select for the remainder unit
  localparam logic [1:0] MSEL_START = 2'd0;
  localparam logic [1:0] MSEL_CK    = 2'd1;
  localparam logic [1:0] MSEL_PROD  = 2'd2;

  typedef struct packed {
    logic             first_entry;
    logic [PER_W-1:0] bus_period;
    logic             last_entry;
  } in_word_t;

  typedef struct packed {
    logic [TS_W-1:0] timestamp;
    logic [1:0]      status;
    logic            is_final;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mod_start;
    logic [1:0] mod_sel;
    logic       first_fin;
    logic       pos_inc;
    logic       set_ovf;
    logic       set_nosol;
    logic       res_load;
    logic       pm_load;
    logic       sieve_step;
    logic       mul_start;
    logic       mul_step;
    logic       commit;
    logic       out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic first;
    logic err_set;
    logic pos_full;
    logic per_zero;
    logic mod_busy;
    logic hit;
    logic t_last;
    logic step_ovf;
    logic mul_last;
    logic mul_ovf;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/crts_mod.sv @@
// Bit-serial remainder unit: 64-bit dividend modulo a 16-bit divisor.
// Depends on crts_pkg; one quotient bit a cycle, one per dividend bit.
module crts_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               dividend,
  input  logic [crts_pkg::PER_W-1:0] divisor,
  output logic                      busy,
  output logic [crts_pkg::PER_W-1:0] rem
);
  import crts_pkg::*;

  logic             busy_r, busy_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [63:0]      dvd_r, dvd_nxt;
  logic [PER_W-1:0] dsr_r, dsr_nxt;
  logic [PER_W-1:0] rem_r, rem_nxt;
  logic [PER_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem_r, dvd_r[63]};
    ge       = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      rem_nxt = ge ? PER_W'(trial - {1'b0, dsr_r}) : trial[PER_W-1:0];
      cnt_nxt = cnt_r + 6'd1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/crts_dp.sv @@
// Datapath of the timestamp sieve: state registers, sieve step, serial multiply.
// Depends on crts_pkg and crts_mod; driven by crts_ctrl commands.
module crts_dp #(
  parameter int MAX_ENTRIES = crts_pkg::MAX_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [crts_pkg::TS_W-1:0] cfg_wr_data,
  input  crts_pkg::in_word_t       in_word,
  input  logic                     out_stall,
  input  crts_pkg::cmd_t           cmd,
  output crts_pkg::sts_t           sts,
  output logic                     out_valid,
  output crts_pkg::out_word_t      out_word
);
  import crts_pkg::*;

  localparam int POS_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ENTRIES);
  localparam int ACC_W = TS_W + PER_W;

  // Architectural state
  logic [TS_W-1:0]  start_r, start_nxt;
  logic [TS_W-1:0]  cand_r, cand_nxt;
  logic [TS_W-1:0]  prod_r, prod_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       err_r, err_nxt;
  // Per-word working registers
  logic             first_r, first_nxt;
  logic             last_r, last_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic [TS_W-1:0]  c_r, c_nxt;
  logic [PER_W-1:0] res_r, res_nxt;
  logic [PER_W-1:0] pm_r, pm_nxt;
  logic [PER_W-1:0] t_r, t_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [3:0]       mcnt_r, mcnt_nxt;
  logic             outv_r, outv_nxt;
  out_word_t        outw_r, outw_nxt;

  logic [63:0]      mod_dvd;
  logic             mod_busy;
  logic [PER_W-1:0] mod_rem;
  logic [PER_W-1:0] up_gap;
  logic [63:0]      up_sum;
  logic [63:0]      step_sum;
  logic [PER_W:0]   res_sum;
  logic [PER_W-1:0] res_add;

  // Pick the dividend for the remainder unit
  always_comb begin
    case (cmd.mod_sel)
      MSEL_START: mod_dvd = {1'b0, start_r};
      MSEL_CK:    mod_dvd = {1'b0, cand_r} + 64'(pos_r);
      default:    mod_dvd = {1'b0, prod_r};
    endcase
  end

  crts_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (per_r),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // Round start up, advance candidate, advance residue modulo the period
  always_comb begin
    up_gap   = per_r - mod_rem;
    up_sum   = {1'b0, start_r} + {{(64-PER_W){1'b0}}, up_gap};
    step_sum = {1'b0, c_r} + {1'b0, prod_r};
    res_sum  = {1'b0, res_r} + {1'b0, pm_r};
    res_add  = (res_sum >= {1'b0, per_r}) ? PER_W'(res_sum - {1'b0, per_r})
                                          : res_sum[PER_W-1:0];
  end

  // Next state of every register, hold by default; out_valid drops once not stalled
  always_comb begin
    start_nxt = cfg_wr_en ? cfg_wr_data : start_r;
    cand_nxt  = cand_r;
    prod_nxt  = prod_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    per_nxt   = per_r;
    c_nxt     = c_r;
    res_nxt   = res_r;
    pm_nxt    = pm_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    mcnt_nxt  = mcnt_r;
    outv_nxt  = outv_r && out_stall;
    outw_nxt  = outw_r;

    if (cmd.load) begin
      first_nxt = in_word.first_entry;
      last_nxt  = in_word.last_entry;
      per_nxt   = (in_word.first_entry && in_word.bus_period == '0) ? PER_W'(1)
                                                                   : in_word.bus_period;
    end
    if (cmd.first_fin) begin
      pos_nxt  = POS_W'(1);
      prod_nxt = TS_W'(per_r);
      if (mod_rem == '0) begin
        cand_nxt = start_r;
        err_nxt  = ST_OK;
      end else if (up_sum[63]) begin
        cand_nxt = '0;
        err_nxt  = ST_OVF;
      end else begin
        cand_nxt = up_sum[TS_W-1:0];
        err_nxt  = ST_OK;
      end
    end
    if (cmd.pos_inc) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (cmd.set_ovf) begin
      err_nxt = ST_OVF;
    end
    if (cmd.set_nosol) begin
      err_nxt = ST_NOSOL;
    end
    if (cmd.res_load) begin
      res_nxt = mod_rem;
      c_nxt   = cand_r;
      t_nxt   = '0;
    end
    if (cmd.pm_load) begin
      pm_nxt = mod_rem;
    end
    if (cmd.sieve_step) begin
      c_nxt   = step_sum[TS_W-1:0];
      res_nxt = res_add;
      t_nxt   = t_r + PER_W'(1);
    end
    // Shift-add multiply, most significant period bit first
    if (cmd.mul_start) begin
      acc_nxt  = '0;
      mcnt_nxt = 4'hF;
    end
    if (cmd.mul_step) begin
      acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} + (per_r[mcnt_r] ? ACC_W'(prod_r) : '0);
      mcnt_nxt = mcnt_r - 4'd1;
    end
    if (cmd.commit) begin
      cand_nxt = c_r;
      prod_nxt = acc_r[TS_W-1:0];
    end
    if (cmd.out_load) begin
      outv_nxt           = 1'b1;
      outw_nxt.timestamp = cand_r;
      outw_nxt.status    = err_r;
      outw_nxt.is_final  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      cand_r  <= '0;
      prod_r  <= TS_W'(1);
      pos_r   <= '0;
      err_r   <= ST_OK;
      outv_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      cand_r  <= cand_nxt;
      prod_r  <= prod_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      outv_r  <= outv_nxt;
    end
    first_r <= first_nxt;
    last_r  <= last_nxt;
    per_r   <= per_nxt;
    c_r     <= c_nxt;
    res_r   <= res_nxt;
    pm_r    <= pm_nxt;
    t_r     <= t_nxt;
    acc_r   <= acc_nxt;
    mcnt_r  <= mcnt_nxt;
    outw_r  <= outw_nxt;
  end

  // Report status to the controller
  always_comb begin
    sts.first    = first_r;
    sts.err_set  = err_r != ST_OK;
    sts.pos_full = pos_r >= POS_MAX;
    sts.per_zero = per_r == '0;
    sts.mod_busy = mod_busy;
    sts.hit      = res_r == '0;
    sts.t_last   = ({1'b0, t_r} + (PER_W+1)'(1)) == {1'b0, per_r};
    sts.step_ovf = step_sum[63];
    sts.mul_last = mcnt_r == 4'd0;
    sts.mul_ovf  = |acc_r[ACC_W-1:TS_W];
    sts.out_free = !outv_r || !out_stall;
  end

  assign out_valid = outv_r;
  assign out_word  = outw_r;

endmodule

@@ rtl/core/crts_ctrl.sv @@
// Controller of the timestamp sieve: sequences remainder, sieve and multiply.
// Depends on crts_pkg; talks to crts_dp through cmd_t and sts_t only.
module crts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  crts_pkg::sts_t sts,
  output crts_pkg::cmd_t cmd
);
  import crts_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FMOD  = 4'd2;
  localparam logic [3:0] S_RMOD  = 4'd3;
  localparam logic [3:0] S_PMOD  = 4'd4;
  localparam logic [3:0] S_SIEVE = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  // Decide the next step and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.first) begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_START;
          state_nxt     = S_FMOD;
        end else if (sts.err_set) begin
          state_nxt = S_OUT;
        end else if (sts.pos_full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = S_OUT;
        end else if (sts.per_zero) begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.pos_inc   = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_CK;
          state_nxt     = S_RMOD;
        end
      end
      S_FMOD: begin
        if (!sts.mod_busy) begin
          cmd.first_fin = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_RMOD: begin
        if (!sts.mod_busy) begin
          cmd.res_load  = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_PROD;
          state_nxt     = S_PMOD;
        end
      end
      S_PMOD: begin
        cmd.mod_sel = MSEL_PROD;
        if (!sts.mod_busy) begin
          cmd.pm_load = 1'b1;
          state_nxt   = S_SIEVE;
        end
      end
      // One trial a cycle: fit, give up, overflow, or step on
      S_SIEVE: begin
        if (sts.hit) begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end else if (sts.t_last) begin
          cmd.set_nosol = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.step_ovf) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.sieve_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.mul_ovf) begin
          cmd.set_ovf = 1'b1;
        end else begin
          cmd.commit = 1'b1;
        end
        state_nxt = S_OUT;
      end
      // Hold until the output register can take the word
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

@@ rtl/core/crt_sieve_timestamp_top.sv @@
// Timestamp sieve, top level: one input word in flight; the next is taken the cycle after
// the result word is loaded, and a stalled result word delays it further.
// A first entry takes one remainder; a later entry takes two remainders, then the sieve
// and, on a fit, a serial multiply; a skipped, errored or over-long entry goes straight
// to the output register.
// Reset (synchronous, rst_n low): start time 0, candidate 0, product 1, position 0.
module crt_sieve_timestamp_top #(
  parameter int MAX_ENTRIES = crts_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [crts_pkg::TS_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  crts_pkg::in_word_t        in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output crts_pkg::out_word_t       out_word
);
  import crts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the work
  crts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold state and do the arithmetic
  crts_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

@@ rtl/core/crts_chk.sv @@
// Port checker for the timestamp sieve, bound to the top level.
// Depends on crts_pkg and crt_sieve_timestamp_top_assert.svh.
`include "crt_sieve_timestamp_top_assert.svh"

module crts_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input crts_pkg::out_word_t out_word
);
  import crts_pkg::*;

  // One word at a time: stall straight after taking a word
  `CRTS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // Status carries only the defined codes
  `CRTS_ASSERT_NOW(a_status_code, out_valid, out_word.status <= ST_OVF)

  // Nothing offered right after reset
  `CRTS_ASSERT_NEXT_ANY(a_reset_empty, !rst_n, !out_valid)

  // A stalled result stays put
  `CRTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind crt_sieve_timestamp_top crts_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
